### src/ucb7_pkg.sv
// ----------------------------------------------------------------------------
// ucb7_pkg: shared types and constants for the up/down counter display block
// Payload structs, phase codes and the seven-segment decode table.
// ----------------------------------------------------------------------------
package ucb7_pkg;

  localparam int unsigned NumDigits  = 5;
  localparam int unsigned CountW     = 7;
  localparam int unsigned SegW       = 8;
  localparam int unsigned OnTimeW    = 8;

  localparam logic [CountW-1:0]  CountMax     = 7'd99;
  localparam logic [CountW-1:0]  Radix        = 7'd10;
  localparam logic [OnTimeW-1:0] OnTimeReset  = 8'd15;
  localparam logic [OnTimeW-1:0] ElapsedMax   = 8'd255;

  // Display phase, one-hot
  typedef enum logic [3:0] {
    PH_ONES   = 4'b0001,
    PH_BLANK0 = 4'b0010,
    PH_TENS   = 4'b0100,
    PH_BLANK1 = 4'b1000
  } phase_e;

  typedef struct packed {
    logic [4:0] up_levels;
    logic [4:0] down_levels;
    logic       ms_tick;
  } in_t;

  typedef struct packed {
    logic        load_strobe;
    logic        column_update;
    logic        column_right;
    logic [39:0] segment_bytes;
    logic [34:0] count_values;
  } out_t;

  // One lane's view of its digit after this item's update
  typedef struct packed {
    logic [CountW-1:0] count;
    logic [SegW-1:0]   seg_ones;
    logic [SegW-1:0]   seg_tens;
  } lane_out_t;

  // Timer/phase status for the merge stage
  typedef struct packed {
    logic   advanced;
    phase_e phase;
  } tmr_status_t;

  function automatic logic [SegW-1:0] seg_pattern(input logic [3:0] digit);
    logic [SegW-1:0] pat;
    case (digit)
      4'd0:    pat = 8'd63;
      4'd1:    pat = 8'd6;
      4'd2:    pat = 8'd91;
      4'd3:    pat = 8'd79;
      4'd4:    pat = 8'd102;
      4'd5:    pat = 8'd109;
      4'd6:    pat = 8'd125;
      4'd7:    pat = 8'd7;
      4'd8:    pat = 8'd127;
      4'd9:    pat = 8'd103;
      default: pat = 8'd0;
    endcase
    return pat;
  endfunction

endpackage

### src/ucb7_lane.sv
// ----------------------------------------------------------------------------
// ucb7_lane: one digit's saturating up/down counter
// Edge-detects the buttons, updates the count, decodes both digit patterns.
// ----------------------------------------------------------------------------
module ucb7_lane import ucb7_pkg::*; #(
  parameter logic [CountW-1:0] ResetCount = 7'd1
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      accept_i,
  input  logic      up_i,
  input  logic      down_i,
  output lane_out_t lane_o
);

  logic              prev_up_q, prev_down_q;
  logic [CountW-1:0] count_q, count_d, count_sat;
  logic [14:0]       tens_prod;
  logic [3:0]        tens;
  logic [CountW-1:0] ones_w;

  always_comb begin
    count_sat = (count_q > CountMax) ? CountMax : count_q;
    count_d   = count_sat;
    if (up_i && !prev_up_q) begin
      if (count_sat < CountMax) count_d = count_sat + 7'd1;
    end else if (down_i && !prev_down_q) begin
      if (count_sat != '0) count_d = count_sat - 7'd1;
    end
  end

  // divide by ten through reciprocal, exact for counts up to 99
  assign tens_prod = 15'(count_d) * 15'd205;
  assign tens      = tens_prod[14:11];
  assign ones_w    = count_d - 7'({3'b000, tens}) * Radix;

  assign lane_o.count    = count_d;
  assign lane_o.seg_ones = seg_pattern(ones_w[3:0]);
  assign lane_o.seg_tens = seg_pattern(tens);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_up_q   <= 1'b1;
      prev_down_q <= 1'b1;
      count_q     <= ResetCount;
    end else if (accept_i) begin
      prev_up_q   <= up_i;
      prev_down_q <= down_i;
      count_q     <= count_d;
    end
  end

endmodule

### src/ucb7_timer.sv
// ----------------------------------------------------------------------------
// ucb7_timer: on-time register, millisecond timer and display phase
// Advances the four-phase display cycle when the on-time is reached.
// ----------------------------------------------------------------------------
module ucb7_timer import ucb7_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic               ms_tick_i,
  input  logic               cfg_we_i,
  input  logic [OnTimeW-1:0] cfg_data_i,
  output tmr_status_t        status_o
);

  logic [OnTimeW-1:0] on_time_q;
  logic [OnTimeW-1:0] elapsed_q, elapsed_d, elapsed_inc;
  phase_e             phase_q, phase_d, phase_next;
  logic               advanced;

  assign elapsed_inc = (ms_tick_i && elapsed_q != ElapsedMax) ? elapsed_q + 8'd1 : elapsed_q;
  assign advanced    = (elapsed_inc >= on_time_q);
  assign elapsed_d   = advanced ? '0 : elapsed_inc;

  always_comb begin
    unique case (phase_q)
      PH_ONES:   phase_next = PH_BLANK0;
      PH_BLANK0: phase_next = PH_TENS;
      PH_TENS:   phase_next = PH_BLANK1;
      PH_BLANK1: phase_next = PH_ONES;
      default:   phase_next = PH_ONES;
    endcase
    phase_d = advanced ? phase_next : phase_q;
  end

  assign status_o.advanced = advanced;
  assign status_o.phase    = phase_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      on_time_q <= OnTimeReset;
    end else if (cfg_we_i) begin
      on_time_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elapsed_q <= '0;
      phase_q   <= PH_ONES;
    end else if (accept_i) begin
      elapsed_q <= elapsed_d;
      phase_q   <= phase_d;
    end
  end

endmodule

### src/ucb7_merge.sv
// ----------------------------------------------------------------------------
// ucb7_merge: combines lane results and phase status into one result
// Picks ones/tens patterns per phase and packs segments and counts.
// ----------------------------------------------------------------------------
module ucb7_merge import ucb7_pkg::*; (
  input  lane_out_t   lanes_i [NumDigits],
  input  tmr_status_t status_i,
  output out_t        result_o
);

  logic [39:0] segs;
  logic [34:0] counts;

  always_comb begin
    segs   = '0;
    counts = '0;
    for (int i = 0; i < NumDigits; i++) begin
      if (status_i.advanced && status_i.phase == PH_ONES) begin
        segs[SegW*i +: SegW] = lanes_i[i].seg_ones;
      end else if (status_i.advanced && status_i.phase == PH_TENS) begin
        segs[SegW*i +: SegW] = lanes_i[i].seg_tens;
      end
      counts[CountW*i +: CountW] = lanes_i[i].count;
    end
  end

  assign result_o.load_strobe   = status_i.advanced;
  assign result_o.column_update = status_i.advanced &&
                                  (status_i.phase == PH_ONES || status_i.phase == PH_TENS);
  assign result_o.column_right  = (status_i.phase == PH_ONES || status_i.phase == PH_BLANK0);
  assign result_o.segment_bytes = segs;
  assign result_o.count_values  = counts;

endmodule

### src/updown_counter_bank_7seg_mux_top.sv
// ----------------------------------------------------------------------------
// updown_counter_bank_7seg_mux_top: five-digit counter bank, muxed display
// Button edges drive saturating counts; a timer steps the display phases.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i): one transfer per
//   sample of the button levels plus the millisecond tick flag.
//   Output channel (out_valid_o / out_stall_i / out_data_o): exactly one
//   result per input transfer, in order.
//   Config channel (cfg_valid_i / cfg_ready_o / cfg_data_i): writes the
//   on-time; always ready. Write only while no result is pending.
// Timing: a result appears in the cycle after its input transfer.
// Throughput: one item per cycle unless stalled; the single output register is
//   refilled in the same cycle it is drained, so sustained rate is set by it.
// Stall: while a result is held and out_stall_i is high, in_stall_o is high
//   and only a config write can change state; the held result stays stable.
// Reset (rst_ni low, async): counts 1..5, previous button levels all ones
//   (no edge on the first sample), phase ones-column, timer zero, on-time 15,
//   output empty.
// ----------------------------------------------------------------------------
module updown_counter_bank_7seg_mux_top import ucb7_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  in_t                in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_t               out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [OnTimeW-1:0] cfg_data_i
);

  logic        out_valid_q;
  out_t        out_data_q;
  out_t        result;
  logic        accept;
  lane_out_t   lanes [NumDigits];
  tmr_status_t status;

  // stall only when a held result is itself blocked
  assign in_stall_o  = out_valid_q && out_stall_i;
  assign accept      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  // one counter lane per digit
  for (genvar g = 0; g < NumDigits; g++) begin : g_lane
    ucb7_lane #(
      .ResetCount(CountW'(g + 1))
    ) u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .accept_i (accept),
      .up_i     (in_data_i.up_levels[g]),
      .down_i   (in_data_i.down_levels[g]),
      .lane_o   (lanes[g])
    );
  end

  ucb7_timer u_timer (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .ms_tick_i  (in_data_i.ms_tick),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .status_o   (status)
  );

  ucb7_merge u_merge (
    .lanes_i  (lanes),
    .status_i (status),
    .result_o (result)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
